### sv/arp_pkg.sv
`timescale 1ns / 1ps

package arp_pkg;

    localparam int IP_W = 32;
    localparam int HW_W = 48;
    localparam int ENTRY_W = IP_W + HW_W;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } t_op;

    typedef struct packed {
        logic            go;
        logic [IP_W-1:0] ip;
    } t_scan_req;

    typedef struct packed {
        logic            done;
        logic            hit;
        logic [HW_W-1:0] hw;
    } t_scan_res;

endpackage

### sv/arp_cache_table.sv
`timescale 1ns / 1ps

// ARP cache: maps IPv4 addresses to 48-bit hardware addresses.
// Input channel: a transaction is taken at a rising edge with start high and
// busy low. operation selects insert (store ip/hw as the newest entry, no
// duplicate check, oldest slot overwritten when full) or lookup.
// Insert: written into the table RAM at the accepting edge, no result; busy
// stays low, so a new transaction may follow in the next cycle.
// Lookup: the table RAM is read one slot per cycle, newest to oldest, and a
// hit ends the scan early. The result (hit, found_address; address is zero on
// a miss) appears for one cycle with o_valid high; each slot's data is
// registered in the table RAM before it is compared, and the result is
// registered again before it shows. busy is high from the cycle after the
// accepting edge until the result cycle.
// The receiver cannot stall: each result is accepted in the cycle it shows.
// Reset (synchronous, active low) clears all valid bits and the insert
// pointer; table contents are left as they are and are never matched.
module arp_cache_table
    import arp_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  logic            i_operation,
    input  logic [IP_W-1:0] i_ip_address,
    input  logic [HW_W-1:0] i_hw_address,
    output logic            o_valid,
    output logic            o_hit,
    output logic [HW_W-1:0] o_found_address
);

    localparam int SLOT_W = $clog2(ENTRIES);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRIES - 1);

    logic [SLOT_W-1:0]  r_next_slot;
    logic [ENTRIES-1:0] r_valid;
    logic               r_out_vld;
    logic               r_out_hit;
    logic [HW_W-1:0]    r_out_hw;

    logic               accept;
    logic               ins;
    logic [SLOT_W-1:0]  first_slot;
    logic [SLOT_W-1:0]  raddr;
    logic [ENTRY_W-1:0] rdata;
    logic               scan_busy;
    t_scan_req          req;
    t_scan_res          res;

    assign accept     = start && !busy;
    assign ins        = accept && (t_op'(i_operation) == OP_INSERT);
    assign first_slot = (r_next_slot == '0) ? LAST_SLOT : r_next_slot - 1'b1;
    assign req.go     = accept && (t_op'(i_operation) == OP_LOOKUP);
    assign req.ip     = i_ip_address;
    assign busy       = scan_busy;

    arp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ins),
        .i_waddr (r_next_slot),
        .i_wdata ({i_ip_address, i_hw_address}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    arp_scan #(
        .ENTRIES (ENTRIES)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req),
        .i_first_slot (first_slot),
        .i_valid      (r_valid),
        .o_raddr      (raddr),
        .i_rdata      (rdata),
        .o_busy       (scan_busy),
        .o_res        (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_slot <= '0;
            r_valid     <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            r_out_vld <= res.done;
            if (ins) begin
                r_valid[r_next_slot] <= 1'b1;
                r_next_slot <= (r_next_slot == LAST_SLOT) ? '0 : r_next_slot + 1'b1;
            end
        end
        r_out_hit <= res.hit;
        r_out_hw  <= res.hw;
    end

    assign o_valid         = r_out_vld;
    assign o_hit           = r_out_hit;
    assign o_found_address = r_out_hw;

endmodule

### sv/arp_ram.sv
`timescale 1ns / 1ps

module arp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/arp_scan.sv
`timescale 1ns / 1ps

module arp_scan
    import arp_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_scan_req                  i_req,
    input  logic [$clog2(ENTRIES)-1:0] i_first_slot,
    input  logic [ENTRIES-1:0]         i_valid,
    output logic [$clog2(ENTRIES)-1:0] o_raddr,
    input  logic [ENTRY_W-1:0]         i_rdata,
    output logic                       o_busy,
    output t_scan_res                  o_res
);

    localparam int SLOT_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRIES - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_scan_state;

    t_scan_state       r_state, n_state;
    logic [SLOT_W-1:0] r_addr, n_addr;
    logic [CNT_W-1:0]  r_left, n_left;
    logic              r_pend, n_pend;
    logic              r_pend_vld, n_pend_vld;
    logic [IP_W-1:0]   r_ip;

    logic match;
    logic last;

    assign match = r_pend && r_pend_vld && (i_rdata[ENTRY_W-1 -: IP_W] == r_ip);
    assign last  = r_pend && (r_left == '0);

    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        n_left     = r_left;
        n_pend     = 1'b0;
        n_pend_vld = 1'b0;
        o_res.done = 1'b0;
        o_res.hit  = match;
        o_res.hw   = i_rdata[HW_W-1:0] & {HW_W{match}};
        unique case (r_state)
            S_IDLE: begin
                if (i_req.go) begin
                    n_state = S_SCAN;
                    n_addr  = i_first_slot;
                    n_left  = FULL_CNT;
                end
            end
            S_SCAN: begin
                if (match || last) begin
                    o_res.done = 1'b1;
                    n_state    = S_IDLE;
                end else if (r_left != '0) begin
                    n_pend     = 1'b1;
                    n_pend_vld = i_valid[r_addr];
                    n_addr     = (r_addr == '0) ? LAST_SLOT : r_addr - 1'b1;
                    n_left     = r_left - 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
        r_addr     <= n_addr;
        r_left     <= n_left;
        r_pend_vld <= n_pend_vld;
        if (i_req.go && r_state == S_IDLE) begin
            r_ip <= i_req.ip;
        end
    end

    assign o_raddr = r_addr;
    assign o_busy  = (r_state != S_IDLE);

endmodule
